[rtl/tldc_pkg.sv]
// ----------------------------------------------------------------------------
// tldc_pkg: shared types and constants for the task load counters
// Field widths, request kind codes and the controller/datapath link types.
// ----------------------------------------------------------------------------
package tldc_pkg;

	localparam int KIND_W = 2;
	localparam int ID_W   = 15;
	localparam int CNT_W  = 32;

	localparam int DEFAULT_TASK_SLOTS = 32;

	localparam logic [CNT_W-1:0] THR_RESET = CNT_W'(200);

	// request kinds
	localparam logic [KIND_W-1:0] KIND_TICK     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_REGISTER = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic load;       // capture the accepted request
		logic mod_step;   // one step of the slot reduction
		logic rd_slot;    // read the request's slot
		logic tick_wr;    // bump slot count and total
		logic reg_wr;     // occupy the slot
		logic rel;        // free the slot if the id matches
		logic out_load;   // load the result register
		logic dec_start;  // clear sweep index and sum
		logic dec_rd;     // read slot at sweep index
		logic dec_wr;     // write back halved count
	} tldc_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              mod_last;
		logic              idx_last;
		logic              over;
		logic              out_busy;
	} tldc_sts_t;

endpackage

[rtl/tldc_if.sv]
// ----------------------------------------------------------------------------
// tldc_if: valid/ready channels of the task load counters
// Request, result and threshold write channels.
// ----------------------------------------------------------------------------
interface tldc_item_if;
	logic                          valid;
	logic                          ready;
	logic [tldc_pkg::KIND_W-1:0]   kind;
	logic [tldc_pkg::ID_W-1:0]     task_id;

	modport source (output valid, kind, task_id, input ready);
	modport sink   (input valid, kind, task_id, output ready);
endinterface

interface tldc_result_if;
	logic                          valid;
	logic                          ready;
	logic                          status;
	logic [tldc_pkg::CNT_W-1:0]    total_ticks;
	logic [tldc_pkg::CNT_W-1:0]    task_ticks;

	modport source (output valid, status, total_ticks, task_ticks, input ready);
	modport sink   (input valid, status, total_ticks, task_ticks, output ready);
endinterface

interface tldc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [tldc_pkg::CNT_W-1:0]    decay_threshold;

	modport source (output valid, decay_threshold, input ready);
	modport sink   (input valid, decay_threshold, output ready);
endinterface

[rtl/task_load_decaying_counters_unit.sv]
// ----------------------------------------------------------------------------
// task_load_decaying_counters_unit: per-task tick load counters
// Slot table of tick counts with a running total and halving decay.
// ----------------------------------------------------------------------------
// Usage:
//   item   : requests (kind, task_id). Tick bumps the task's slot and the
//            total; query returns status/total/slot count; register occupies
//            and clears a slot; release frees a slot holding that id.
//   result : one item per query, none for other kinds.
//   cfg    : writes decay_threshold; write only while the block is idle.
//   A slot is task_id modulo TASK_SLOTS, found by a reciprocal multiply
//   (quotient, then remainder). The registered table read and the execute
//   step follow, and only then is the next request accepted. A tick also
//   goes through the threshold compare, and when it decays, through the
//   read/halve/write sweep over every slot.
//   A query result is loaded into an output register at its execute step;
//   a stalled receiver blocks only the next query at its execute step.
//   Reset clears all slots, the total and the result channel, and sets the
//   threshold to 200; the block takes requests right after reset.
// ----------------------------------------------------------------------------
module task_load_decaying_counters_unit #(
	parameter int TASK_SLOTS = tldc_pkg::DEFAULT_TASK_SLOTS
) (
	input  logic          clk,
	input  logic          arst_n,
	tldc_item_if.sink     item,
	tldc_result_if.source result,
	tldc_cfg_if.sink      cfg
);

	tldc_pkg::tldc_cmd_t cmd;
	tldc_pkg::tldc_sts_t sts;

	assign cfg.ready = 1'b1;

	tldc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tldc_dp #(
		.TASK_SLOTS (TASK_SLOTS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_kind         (item.kind),
		.in_task_id      (item.task_id),
		.cfg_we          (cfg.valid),
		.cfg_data        (cfg.decay_threshold),
		.out_valid       (result.valid),
		.out_ready       (result.ready),
		.out_status      (result.status),
		.out_total_ticks (result.total_ticks),
		.out_task_ticks  (result.task_ticks)
	);

endmodule

[rtl/tldc_ctrl.sv]
// ----------------------------------------------------------------------------
// tldc_ctrl: sequencer of the task load counters
// Walks each request through slot reduction, slot read, execute and decay.
// ----------------------------------------------------------------------------
module tldc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tldc_pkg::tldc_sts_t sts,
	output tldc_pkg::tldc_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MOD  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_EXEC = 3'd3;
	localparam logic [2:0] ST_TCHK = 3'd4;
	localparam logic [2:0] ST_DRD  = 3'd5;
	localparam logic [2:0] ST_DWR  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_MOD;
				end
			end
			ST_MOD: begin
				cmd.mod_step = 1'b1;
				if (sts.mod_last) state_nx = ST_RD;
			end
			ST_RD: begin
				cmd.rd_slot = 1'b1;
				state_nx    = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (sts.kind)
					tldc_pkg::KIND_TICK: begin
						cmd.tick_wr = 1'b1;
						state_nx    = ST_TCHK;
					end
					tldc_pkg::KIND_QUERY: begin
						// hold here until the result register frees up
						if (!sts.out_busy) begin
							cmd.out_load = 1'b1;
							state_nx     = ST_IDLE;
						end
					end
					tldc_pkg::KIND_REGISTER: begin
						cmd.reg_wr = 1'b1;
						state_nx   = ST_IDLE;
					end
					tldc_pkg::KIND_RELEASE: begin
						cmd.rel  = 1'b1;
						state_nx = ST_IDLE;
					end
					default: state_nx = ST_IDLE;
				endcase
			end
			ST_TCHK: begin
				if (sts.over) begin
					cmd.dec_start = 1'b1;
					state_nx      = ST_DRD;
				end else begin
					state_nx = ST_IDLE;
				end
			end
			ST_DRD: begin
				cmd.dec_rd = 1'b1;
				state_nx   = ST_DWR;
			end
			ST_DWR: begin
				cmd.dec_wr = 1'b1;
				state_nx   = sts.idx_last ? ST_IDLE : ST_DRD;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

endmodule

[rtl/tldc_dp.sv]
// ----------------------------------------------------------------------------
// tldc_dp: datapath of the task load counters
// Slot remainder unit, count and id memories, occupancy flags, total,
// decay sum and the result register.
// ----------------------------------------------------------------------------
module tldc_dp #(
	parameter int TASK_SLOTS = tldc_pkg::DEFAULT_TASK_SLOTS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tldc_pkg::tldc_cmd_t           cmd,
	output tldc_pkg::tldc_sts_t           sts,
	input  logic [tldc_pkg::KIND_W-1:0]   in_kind,
	input  logic [tldc_pkg::ID_W-1:0]     in_task_id,
	input  logic                          cfg_we,
	input  logic [tldc_pkg::CNT_W-1:0]    cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          out_status,
	output logic [tldc_pkg::CNT_W-1:0]    out_total_ticks,
	output logic [tldc_pkg::CNT_W-1:0]    out_task_ticks
);

	localparam int ID_W   = tldc_pkg::ID_W;
	localparam int CNT_W  = tldc_pkg::CNT_W;
	localparam int SLOT_W = $clog2(TASK_SLOTS);
	localparam int MCNT_W = 1;
	localparam int RCP_W  = ID_W + 2;
	localparam int PROD_W = ID_W + RCP_W;
	localparam int RSH    = ID_W + SLOT_W;

	localparam logic [ID_W-1:0]   SLOTS_C = ID_W'(TASK_SLOTS);
	localparam logic [RCP_W-1:0]  RCP_C   =
		RCP_W'(((1 << RSH) + TASK_SLOTS - 1) / TASK_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_C  = SLOT_W'(TASK_SLOTS - 1);
	localparam logic [MCNT_W-1:0] MLAST_C = MCNT_W'(1);

	// request registers
	logic [tldc_pkg::KIND_W-1:0] kind_q;
	logic [ID_W-1:0]             id_q;
	logic [ID_W-1:0]             quo_q;
	logic [MCNT_W-1:0]           mcnt_q;
	logic [SLOT_W-1:0]           slot_q;
	logic [PROD_W-1:0]           prod;
	logic [ID_W-1:0]             rem_full;

	// state
	logic [CNT_W-1:0]      thr_q;
	logic [CNT_W-1:0]      total_q;
	logic [CNT_W-1:0]      sum_q;
	logic [SLOT_W-1:0]     idx_q;
	logic [TASK_SLOTS-1:0] vld_q;
	logic [TASK_SLOTS-1:0] init_q;   // count entry written since reset

	// memories
	logic [CNT_W-1:0] cnt_mem [TASK_SLOTS];
	logic [ID_W-1:0]  id_mem  [TASK_SLOTS];
	logic [CNT_W-1:0] cnt_rd_q;
	logic [ID_W-1:0]  id_rd_q;
	logic             init_rd_q;

	logic [SLOT_W-1:0] addr;
	logic              rd_en;
	logic              cnt_we;
	logic [CNT_W-1:0]  cnt_wdata;
	logic [CNT_W-1:0]  cnt_eff;
	logic [CNT_W-1:0]  half;
	logic [CNT_W-1:0]  sum_nx;
	logic              hit;

	logic             out_valid_q;
	logic             out_status_q;
	logic [CNT_W-1:0] out_total_q;
	logic [CNT_W-1:0] out_task_q;

	// slot by reciprocal multiply: quotient on the first step,
	// remainder on the second
	assign prod     = PROD_W'(id_q) * PROD_W'(RCP_C);
	assign rem_full = id_q - quo_q * SLOTS_C;

	assign addr    = (cmd.dec_rd || cmd.dec_wr) ? idx_q : slot_q;
	assign rd_en   = cmd.rd_slot || cmd.dec_rd;
	assign cnt_eff = init_rd_q ? cnt_rd_q : '0;
	assign half    = cnt_eff >> 1;
	assign sum_nx  = sum_q + half;
	assign hit     = vld_q[slot_q] && (id_rd_q == id_q);

	always_comb begin
		cnt_we    = 1'b0;
		cnt_wdata = '0;
		if (cmd.tick_wr) begin
			cnt_we    = 1'b1;
			cnt_wdata = cnt_eff + CNT_W'(1);
		end else if (cmd.reg_wr) begin
			cnt_we    = 1'b1;
			cnt_wdata = '0;
		end else if (cmd.dec_wr) begin
			cnt_we    = 1'b1;
			cnt_wdata = half;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			id_q   <= in_task_id;
		end else if (cmd.mod_step) begin
			quo_q <= ID_W'(prod >> RSH);
		end
		if (cnt_we) cnt_mem[addr] <= cnt_wdata;
		if (cmd.reg_wr) id_mem[addr] <= id_q;
		if (rd_en) begin
			cnt_rd_q  <= cnt_mem[addr];
			id_rd_q   <= id_mem[addr];
			init_rd_q <= init_q[addr];
		end
		if (cmd.out_load) begin
			out_status_q <= !hit;
			out_total_q  <= hit ? total_q : '0;
			out_task_q   <= hit ? cnt_eff : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q      <= '0;
			slot_q      <= '0;
			thr_q       <= tldc_pkg::THR_RESET;
			total_q     <= '0;
			sum_q       <= '0;
			idx_q       <= '0;
			vld_q       <= '0;
			init_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) thr_q <= cfg_data;
			if (cmd.load) begin
				mcnt_q <= '0;
				slot_q <= '0;
			end else if (cmd.mod_step) begin
				mcnt_q <= mcnt_q + MCNT_W'(1);
				slot_q <= rem_full[SLOT_W-1:0];
			end
			if (cnt_we) init_q[addr] <= 1'b1;
			if (cmd.tick_wr) total_q <= total_q + CNT_W'(1);
			if (cmd.reg_wr) vld_q[slot_q] <= 1'b1;
			if (cmd.rel && hit) vld_q[slot_q] <= 1'b0;
			if (cmd.dec_start) begin
				idx_q <= '0;
				sum_q <= '0;
			end else if (cmd.dec_wr) begin
				idx_q <= idx_q + SLOT_W'(1);
				sum_q <= sum_nx;
				if (idx_q == LAST_C) total_q <= sum_nx;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.kind     = kind_q;
	assign sts.mod_last = (mcnt_q == MLAST_C);
	assign sts.idx_last = (idx_q == LAST_C);
	assign sts.over     = (total_q > thr_q);
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid       = out_valid_q;
	assign out_status      = out_status_q;
	assign out_total_ticks = out_total_q;
	assign out_task_ticks  = out_task_q;

endmodule

[test/tldc_load_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tldc_load_checker: load counter predictor and result scoreboard
// Watches the request, result and threshold channels. It keeps its own
// slot table and running total, computes the reply for each query, and
// checks every result against the oldest reply still due.
// ----------------------------------------------------------------------------
module tldc_load_checker #(
	parameter int SLOTS = tldc_pkg::DEFAULT_TASK_SLOTS
) (
	input  logic   clk,
	input  logic   arst_n,
	tldc_item_if   item_mon,
	tldc_result_if result_mon,
	tldc_cfg_if    cfg_mon,
	output int     fail_count,
	output int     replies_due
);

	typedef struct packed {
		logic                       status;
		logic [tldc_pkg::CNT_W-1:0] total;
		logic [tldc_pkg::CNT_W-1:0] slot;
	} load_reply_t;

	load_reply_t replies_q[$];

	bit [tldc_pkg::CNT_W-1:0] threshold_now = tldc_pkg::THR_RESET;
	bit                       slot_live[SLOTS];
	bit [tldc_pkg::ID_W-1:0]  slot_owner[SLOTS];
	bit [tldc_pkg::CNT_W-1:0] slot_ticks[SLOTS];
	bit [tldc_pkg::CNT_W-1:0] ticks_total;
	int                       mismatches = 0;
	int                       due_count = 0;

	assign fail_count  = mismatches;
	assign replies_due = due_count;

	task automatic report(input string msg);
		mismatches++;
		$display("ERROR at %0t: %s", $time, msg);
	endtask

	function automatic void apply_request(input logic [tldc_pkg::KIND_W-1:0] k,
			input logic [tldc_pkg::ID_W-1:0] id);
		int s;
		bit [tldc_pkg::CNT_W-1:0] sum;
		load_reply_t r;
		s = id % SLOTS;
		case (k)
			tldc_pkg::KIND_TICK: begin
				// counts on the slot whoever owns it
				slot_ticks[s] += 1;
				ticks_total += 1;
				if (ticks_total > threshold_now) begin
					sum = '0;
					for (int i = 0; i < SLOTS; i++) begin
						slot_ticks[i] >>= 1;
						sum += slot_ticks[i];
					end
					ticks_total = sum;
				end
			end
			tldc_pkg::KIND_QUERY: begin
				if (slot_live[s] && slot_owner[s] == id) begin
					r = '{1'b0, ticks_total, slot_ticks[s]};
				end else begin
					r = '{1'b1, '0, '0};
				end
				replies_q.push_back(r);
			end
			tldc_pkg::KIND_REGISTER: begin
				slot_live[s]  = 1'b1;
				slot_owner[s] = id;
				slot_ticks[s] = '0;
			end
			default: begin
				// count survives the release and still decays
				if (slot_live[s] && slot_owner[s] == id) begin
					slot_live[s] = 1'b0;
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		load_reply_t want;
		if (!arst_n) begin
			threshold_now = tldc_pkg::THR_RESET;
			ticks_total   = '0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_live[i]  = 1'b0;
				slot_owner[i] = '0;
				slot_ticks[i] = '0;
			end
			replies_q.delete();
		end else begin
			if (result_mon.valid && result_mon.ready) begin
				if (replies_q.size() == 0) begin
					report($sformatf("result with no query waiting: %0d %0h %0h",
						result_mon.status, result_mon.total_ticks, result_mon.task_ticks));
				end else begin
					want = replies_q.pop_front();
					if (result_mon.status !== want.status) begin
						report($sformatf("status got %0d expected %0d",
							result_mon.status, want.status));
					end
					if (result_mon.total_ticks !== want.total) begin
						report($sformatf("total_ticks got %0h expected %0h",
							result_mon.total_ticks, want.total));
					end
					if (result_mon.task_ticks !== want.slot) begin
						report($sformatf("task_ticks got %0h expected %0h",
							result_mon.task_ticks, want.slot));
					end
				end
			end
			if (cfg_mon.valid && cfg_mon.ready) begin
				threshold_now = cfg_mon.decay_threshold;
			end
			if (item_mon.valid && item_mon.ready) begin
				apply_request(item_mon.kind, item_mon.task_id);
			end
		end
		due_count = replies_q.size();
	end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus for the task load counters
// Directed requests over slot ownership corner cases, then random phases
// under several decay thresholds and idling mixes, with a long result
// stall. Checking is done by tldc_load_checker.
// ----------------------------------------------------------------------------
module testbench;

	localparam int SETTLE_CYCLES    = 100;
	localparam int HOLD_OFF_CYCLES  = 600;
	localparam int PHASES           = 8;
	localparam int RANDOM_PER_PHASE = 145;
	localparam int POOL_SIZE        = 24;

	logic clk;
	logic arst_n;

	int send_gap_pct;
	int recv_gap_pct;
	bit hold_off_req;
	bit hold_off_ack;
	int hold_left;
	int mismatches;
	int replies_due;

	bit [tldc_pkg::ID_W-1:0]  id_pool[POOL_SIZE];
	bit [tldc_pkg::CNT_W-1:0] thresholds[PHASES];

	tldc_item_if   item_bus();
	tldc_result_if result_bus();
	tldc_cfg_if    cfg_bus();

	task_load_decaying_counters_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_bus),
		.result (result_bus),
		.cfg    (cfg_bus)
	);

	tldc_load_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_mon    (item_bus),
		.result_mon  (result_bus),
		.cfg_mon     (cfg_bus),
		.fail_count  (mismatches),
		.replies_due (replies_due)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// result side: random backpressure, or a long hold when requested
	initial begin
		result_bus.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_off_req != hold_off_ack) begin
				hold_off_ack = hold_off_req;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_bus.ready = 1'b0;
			end else begin
				result_bus.ready = ($urandom_range(99) >= recv_gap_pct);
			end
		end
	end

	task automatic set_idling(input int mode);
		case (mode)
			0: begin
				send_gap_pct = 16;
				recv_gap_pct = 59;
			end
			1: begin
				send_gap_pct = 59;
				recv_gap_pct = 16;
			end
			default: begin
				send_gap_pct = 0;
				recv_gap_pct = 0;
			end
		endcase
	endtask

	// called at a falling edge, returns at a falling edge
	task automatic offer_request(input logic [tldc_pkg::KIND_W-1:0] k,
			input logic [tldc_pkg::ID_W-1:0] id);
		while ($urandom_range(99) < send_gap_pct) begin
			item_bus.valid = 1'b0;
			@(negedge clk);
		end
		item_bus.valid   = 1'b1;
		item_bus.kind    = k;
		item_bus.task_id = id;
		@(posedge clk);
		while (!item_bus.ready) @(posedge clk);
		@(negedge clk);
		item_bus.valid = 1'b0;
	endtask

	task automatic write_threshold(input logic [tldc_pkg::CNT_W-1:0] value);
		cfg_bus.valid = 1'b1;
		cfg_bus.decay_threshold = value;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		@(negedge clk);
		cfg_bus.valid = 1'b0;
	endtask

	// pause until every reply is in, then let a decay sweep finish
	task automatic wait_replies_done();
		while (replies_due != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [tldc_pkg::ID_W-1:0] pick_id();
		if ($urandom_range(99) < 80) begin
			return id_pool[$urandom_range(POOL_SIZE - 1)];
		end
		return tldc_pkg::ID_W'($urandom);
	endfunction

	function automatic logic [tldc_pkg::KIND_W-1:0] pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 45) begin
			return tldc_pkg::KIND_TICK;
		end else if (r < 75) begin
			return tldc_pkg::KIND_QUERY;
		end else if (r < 88) begin
			return tldc_pkg::KIND_REGISTER;
		end
		return tldc_pkg::KIND_RELEASE;
	endfunction

	initial begin
		item_bus.valid   = 1'b0;
		item_bus.kind    = tldc_pkg::KIND_TICK;
		item_bus.task_id = '0;
		cfg_bus.valid    = 1'b0;
		cfg_bus.decay_threshold = tldc_pkg::THR_RESET;
		arst_n = 1'b0;
		hold_off_req = 1'b0;
		set_idling(0);
		foreach (id_pool[i]) id_pool[i] = tldc_pkg::ID_W'($urandom);

		thresholds[0] = 32'd1;
		thresholds[1] = 32'd0;
		thresholds[2] = 32'hFFFF_FFFF;
		thresholds[3] = 32'hFFFF_FFFE;
		thresholds[4] = 32'd5;
		thresholds[5] = $urandom_range(400, 2);
		thresholds[6] = tldc_pkg::THR_RESET;
		thresholds[7] = 32'd40;

		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: ownership corners at the reset threshold
		offer_request(tldc_pkg::KIND_QUERY,    15'd0);       // empty slot
		offer_request(tldc_pkg::KIND_REGISTER, 15'd0);
		offer_request(tldc_pkg::KIND_REGISTER, 15'h7FFF);
		offer_request(tldc_pkg::KIND_QUERY,    15'd0);       // found, no ticks yet
		offer_request(tldc_pkg::KIND_TICK,     15'd0);
		offer_request(tldc_pkg::KIND_TICK,     15'd0);
		offer_request(tldc_pkg::KIND_TICK,     15'd32);      // foreign id, same slot
		offer_request(tldc_pkg::KIND_TICK,     15'd5);       // empty slot
		offer_request(tldc_pkg::KIND_QUERY,    15'd0);
		offer_request(tldc_pkg::KIND_QUERY,    15'd32);      // slot held by another id
		offer_request(tldc_pkg::KIND_QUERY,    15'h7FFF);
		offer_request(tldc_pkg::KIND_RELEASE,  15'd32);      // id mismatch, ignored
		offer_request(tldc_pkg::KIND_RELEASE,  15'd5);       // empty slot, ignored
		offer_request(tldc_pkg::KIND_RELEASE,  15'd0);
		offer_request(tldc_pkg::KIND_QUERY,    15'd0);       // released
		offer_request(tldc_pkg::KIND_TICK,     15'd0);       // tick on a released slot
		offer_request(tldc_pkg::KIND_REGISTER, 15'h5555);
		offer_request(tldc_pkg::KIND_TICK,     15'h5555);
		offer_request(tldc_pkg::KIND_TICK,     15'h2AAA);
		offer_request(tldc_pkg::KIND_QUERY,    15'h5555);
		offer_request(tldc_pkg::KIND_REGISTER, 15'd0);       // clears the count
		offer_request(tldc_pkg::KIND_QUERY,    15'd0);
		offer_request(tldc_pkg::KIND_RELEASE,  15'h7FFF);
		offer_request(tldc_pkg::KIND_QUERY,    15'h7FFF);
		wait_replies_done();

		for (int p = 0; p < PHASES; p++) begin
			write_threshold(thresholds[p]);
			set_idling(p % 3);
			if (p == 2) begin
				// long result stall while queries keep coming
				hold_off_req = ~hold_off_req;
				repeat (20) offer_request(tldc_pkg::KIND_QUERY,
					id_pool[$urandom_range(POOL_SIZE - 1)]);
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				offer_request(pick_kind(), pick_id());
			end
			wait_replies_done();
		end

		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[task_load_decaying_counters_unit.f]
rtl/tldc_pkg.sv
rtl/tldc_if.sv
rtl/tldc_ctrl.sv
rtl/tldc_dp.sv
rtl/task_load_decaying_counters_unit.sv
test/tldc_load_checker.sv
test/testbench.sv
